// File: rtl/core/lcdws_pkg.sv
// ============================================================================
// Character LCD text window scroller: shared package
// Holds the item types, the line buffer control types and the display
// command constants used by the control sequencer and the buffer cells.
// ============================================================================
package lcdws_pkg;

    // Number of characters on one display line and in the scroll buffer.
    localparam int LINE_WIDTH = 16;

    // Fill count holds 0..LINE_WIDTH, the rotation counter 0..LINE_WIDTH-1.
    localparam int FILL_W = $clog2(LINE_WIDTH + 1);
    localparam int IDX_W  = $clog2(LINE_WIDTH);

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_WIDTH);
    localparam logic [IDX_W-1:0]  ROT_LAST = IDX_W'(LINE_WIDTH - 1);
    // Column bound widened so that line widths beyond the 5-bit column fit.
    localparam logic [6:0]        COL_LIMIT = 7'(LINE_WIDTH);

    // Opcodes of an input item.
    localparam logic [2:0] OP_WIN_PRINT    = 3'd0;
    localparam logic [2:0] OP_SCROLL_PRINT = 3'd1;
    localparam logic [2:0] OP_CLR_DISPLAY  = 3'd2;
    localparam logic [2:0] OP_SET_CURSOR   = 3'd3;
    localparam logic [2:0] OP_CLR_BUFFER   = 3'd4;

    // Display command constants.
    localparam logic [7:0] CMD_ROW1_BASE = 8'h80;
    localparam logic [7:0] CMD_ROW2_BASE = 8'hC0;
    localparam logic [3:0] CLR_NIB_HI    = 4'h0;
    localparam logic [3:0] CLR_NIB_LO    = 4'h1;
    localparam logic [7:0] CHAR_SPACE    = 8'd32;
    localparam logic [7:0] CHAR_NUL      = 8'd0;

    localparam logic [1:0] ROW_ONE = 2'd1;
    localparam logic [1:0] ROW_TWO = 2'd2;
    localparam logic [1:0] ROW_OVF = 2'd3;
    localparam logic [4:0] COL_ONE = 5'd1;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_value;
        logic [1:0] cursor_row;
        logic [4:0] cursor_col;
    } lcdws_in_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic       is_data;
        logic       last;
    } lcdws_out_t;

    // Command shared by every buffer cell.
    typedef struct packed {
        logic       clear;    // load a space
        logic       shift;    // take the right-hand neighbor's character
        logic [7:0] wr_data;  // character written by a selected cell
    } cell_ctrl_t;

    // Everything the sequencer drives into the cell row.
    typedef struct packed {
        cell_ctrl_t            common;
        logic [LINE_WIDTH-1:0] wr_sel;     // one-hot write select
        logic [7:0]            tail_data;  // enters the last cell on a shift
    } buf_ctrl_t;

endpackage

// File: rtl/core/char_lcd_text_window_scroller.sv
// ============================================================================
// Character LCD text window scroller: top level
// Turns print, cursor and clear requests into nibble writes for a two-row
// character display on a 4-bit bus.
// ============================================================================
// Each input item carries an opcode (window print, scroll print, clear
// display, set cursor, clear scroll buffer) and the result channel gives the
// nibble writes the display needs, high nibble first, each flagged as command
// or character data, with last set on the final nibble of the item. Items
// that produce nothing (clear scroll buffer, unknown opcodes) finish in the
// cycle they are accepted. A window print gives 2, 4 or 6 nibble writes, set
// cursor and clear display give 2. A scroll print updates the line buffer
// when it is accepted, then gives the 2 nibbles of the cursor command and 2
// per buffered character, so up to 34 writes for a full line of 16. The line
// buffer is a row of character cells that rotates one position for every
// character sent; after the last character the row keeps rotating, one cell
// a cycle without output, until a full revolution of LINE_WIDTH steps puts
// it back in line order, and only then is the next item accepted. Results
// are held in an output register, so a new item can be taken while the
// previous final nibble still waits for the sink.
module char_lcd_text_window_scroller import lcdws_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lcdws_in_t  s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output lcdws_out_t m_item
);

    buf_ctrl_t  buf_ctrl;
    logic [7:0] cell_q [LINE_WIDTH];

    // The sequencer reads the head of the row for output and the next cell
    // to decide whether the current character is the last one to send.
    lcdws_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .head_char (cell_q[0]),
        .next_char (cell_q[1]),
        .buf_ctrl  (buf_ctrl)
    );

    // Cell 0 is the start of the line. On a shift every cell takes its right
    // neighbor; the last cell takes either the new character (scroll insert)
    // or the head character (rotation during sending).
    for (genvar i = 0; i < LINE_WIDTH; i++) begin : g_cell
        logic [7:0] right_char;

        if (i == LINE_WIDTH - 1) begin : g_tail
            assign right_char = buf_ctrl.tail_data;
        end else begin : g_body
            assign right_char = cell_q[i+1];
        end

        lcdws_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (buf_ctrl.common),
            .wr_en      (buf_ctrl.wr_sel[i]),
            .right_char (right_char),
            .char_q     (cell_q[i])
        );
    end

endmodule

// File: rtl/core/lcdws_cell.sv
// ============================================================================
// Character LCD text window scroller: line buffer cell
// Holds one character of the scroll line; on command it loads a space, takes
// a written character or shifts it toward the head of the row.
// ============================================================================
module lcdws_cell import lcdws_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       wr_en,
    input  logic [7:0] right_char,
    output logic [7:0] char_q
);

    logic [7:0] char_reg;
    logic [7:0] char_next;

    always_comb begin
        char_next = char_reg;
        if (ctrl.clear) begin
            char_next = CHAR_SPACE;
        end else if (ctrl.shift) begin
            char_next = right_char;
        end else if (wr_en) begin
            char_next = ctrl.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_reg <= CHAR_SPACE;
        end else begin
            char_reg <= char_next;
        end
    end

    assign char_q = char_reg;

endmodule

// File: rtl/core/lcdws_ctrl.sv
// ============================================================================
// Character LCD text window scroller: control sequencer
// Decodes each item, tracks the cursor position and the buffer fill, steps
// through the nibble writes and drives the output register and the cells.
// ============================================================================
module lcdws_ctrl import lcdws_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lcdws_in_t  s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output lcdws_out_t m_item,
    input  logic [7:0] head_char,
    input  logic [7:0] next_char,
    output buf_ctrl_t  buf_ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR_HI,
        ST_CLR_LO,
        ST_CUR_HI,
        ST_CUR_LO,
        ST_CHR_HI,
        ST_CHR_LO,
        ST_BUF_HI,
        ST_BUF_LO,
        ST_ROT
    } state_t;

    typedef enum logic [1:0] {
        KIND_WINDOW,
        KIND_SCROLL,
        KIND_CLEAR,
        KIND_CURSOR
    } kind_t;

    state_t            state_reg,       state_next;
    kind_t             kind_reg,        kind_next;
    logic [1:0]        tracked_row_reg, tracked_row_next;
    logic [4:0]        tracked_col_reg, tracked_col_next;
    logic [FILL_W-1:0] fill_cnt_reg,    fill_cnt_next;
    logic [IDX_W-1:0]  rot_cnt_reg,     rot_cnt_next;
    logic [7:0]        addr_reg,        addr_next;
    logic [7:0]        char_reg,        char_next;
    logic              m_valid_reg,     m_valid_next;
    lcdws_out_t        m_item_reg,      m_item_next;

    logic       accept;
    logic       emit_ok;
    logic       emit;
    logic [3:0] emit_nib;
    logic       emit_data;
    logic       emit_last;
    logic [4:0] col_inc;
    logic [1:0] row_inc;
    logic [7:0] row_base;
    logic       rot_fin;
    logic       buf_stop;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign emit_ok = !m_valid_reg || m_ready;

    always_comb begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        tracked_row_next = tracked_row_reg;
        tracked_col_next = tracked_col_reg;
        fill_cnt_next    = fill_cnt_reg;
        rot_cnt_next     = rot_cnt_reg;
        addr_next        = addr_reg;
        char_next        = char_reg;

        emit      = 1'b0;
        emit_nib  = 4'h0;
        emit_data = 1'b0;
        emit_last = 1'b0;

        col_inc  = tracked_col_reg + 5'd1;
        row_inc  = tracked_row_reg + 2'd1;
        row_base = (s_item.cursor_row == ROW_ONE) ? CMD_ROW1_BASE : CMD_ROW2_BASE;
        rot_fin  = (rot_cnt_reg == ROT_LAST);
        buf_stop = rot_fin || (next_char == CHAR_NUL);

        buf_ctrl.common.clear   = 1'b0;
        buf_ctrl.common.shift   = 1'b0;
        buf_ctrl.common.wr_data = s_item.char_value;
        buf_ctrl.wr_sel         = '0;
        buf_ctrl.tail_data      = head_char;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_item.opcode)
                        OP_WIN_PRINT: begin
                            kind_next = KIND_WINDOW;
                            char_next = s_item.char_value;
                            if ({2'b00, col_inc} > COL_LIMIT) begin
                                // Column ran off the line: wrap to the next row,
                                // clearing the display after the second row.
                                if (row_inc == ROW_OVF) begin
                                    row_inc    = ROW_ONE;
                                    state_next = ST_CLR_HI;
                                end else begin
                                    state_next = ST_CUR_HI;
                                end
                                tracked_row_next = row_inc;
                                tracked_col_next = COL_ONE;
                                addr_next = (row_inc == ROW_ONE) ? CMD_ROW1_BASE
                                                                 : CMD_ROW2_BASE;
                            end else begin
                                tracked_col_next = col_inc;
                                state_next       = ST_CHR_HI;
                            end
                        end
                        OP_SCROLL_PRINT: begin
                            kind_next        = KIND_SCROLL;
                            addr_next        = CMD_ROW2_BASE;
                            tracked_row_next = ROW_TWO;
                            tracked_col_next = COL_ONE;
                            state_next       = ST_CUR_HI;
                            if (fill_cnt_reg < FILL_MAX) begin
                                for (int i = 0; i < LINE_WIDTH; i++) begin
                                    buf_ctrl.wr_sel[i] = (fill_cnt_reg == FILL_W'(i));
                                end
                                fill_cnt_next = fill_cnt_reg + FILL_W'(1);
                            end else begin
                                buf_ctrl.common.shift = 1'b1;
                                buf_ctrl.tail_data    = s_item.char_value;
                            end
                        end
                        OP_CLR_DISPLAY: begin
                            kind_next        = KIND_CLEAR;
                            tracked_row_next = ROW_ONE;
                            tracked_col_next = COL_ONE;
                            state_next       = ST_CLR_HI;
                        end
                        OP_SET_CURSOR: begin
                            kind_next        = KIND_CURSOR;
                            addr_next        = row_base + {3'b000, s_item.cursor_col}
                                               - 8'd1;
                            tracked_row_next = s_item.cursor_row;
                            tracked_col_next = s_item.cursor_col;
                            state_next       = ST_CUR_HI;
                        end
                        OP_CLR_BUFFER: begin
                            buf_ctrl.common.clear = 1'b1;
                            fill_cnt_next         = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLR_HI: begin
                if (emit_ok) begin
                    emit       = 1'b1;
                    emit_nib   = CLR_NIB_HI;
                    state_next = ST_CLR_LO;
                end
            end
            ST_CLR_LO: begin
                if (emit_ok) begin
                    emit       = 1'b1;
                    emit_nib   = CLR_NIB_LO;
                    emit_last  = (kind_reg == KIND_CLEAR);
                    state_next = (kind_reg == KIND_CLEAR) ? ST_IDLE : ST_CUR_HI;
                end
            end
            ST_CUR_HI: begin
                if (emit_ok) begin
                    emit       = 1'b1;
                    emit_nib   = addr_reg[7:4];
                    state_next = ST_CUR_LO;
                end
            end
            ST_CUR_LO: begin
                if (emit_ok) begin
                    emit     = 1'b1;
                    emit_nib = addr_reg[3:0];
                    case (kind_reg)
                        KIND_WINDOW: begin
                            state_next = ST_CHR_HI;
                        end
                        KIND_SCROLL: begin
                            if (head_char == CHAR_NUL) begin
                                emit_last  = 1'b1;
                                state_next = ST_ROT;
                            end else begin
                                state_next = ST_BUF_HI;
                            end
                        end
                        default: begin
                            emit_last  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHR_HI: begin
                if (emit_ok) begin
                    emit       = 1'b1;
                    emit_nib   = char_reg[7:4];
                    emit_data  = 1'b1;
                    state_next = ST_CHR_LO;
                end
            end
            ST_CHR_LO: begin
                if (emit_ok) begin
                    emit       = 1'b1;
                    emit_nib   = char_reg[3:0];
                    emit_data  = 1'b1;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_BUF_HI: begin
                if (emit_ok) begin
                    emit       = 1'b1;
                    emit_nib   = head_char[7:4];
                    emit_data  = 1'b1;
                    state_next = ST_BUF_LO;
                end
            end
            ST_BUF_LO: begin
                if (emit_ok) begin
                    emit                  = 1'b1;
                    emit_nib              = head_char[3:0];
                    emit_data             = 1'b1;
                    emit_last             = buf_stop;
                    buf_ctrl.common.shift = 1'b1;
                    rot_cnt_next          = rot_fin ? '0 : rot_cnt_reg + IDX_W'(1);
                    if (rot_fin) begin
                        state_next = ST_IDLE;
                    end else if (buf_stop) begin
                        state_next = ST_ROT;
                    end else begin
                        state_next = ST_BUF_HI;
                    end
                end
            end
            ST_ROT: begin
                // Finish the revolution so the buffer is back in line order.
                buf_ctrl.common.shift = 1'b1;
                if (rot_fin) begin
                    rot_cnt_next = '0;
                    state_next   = ST_IDLE;
                end else begin
                    rot_cnt_next = rot_cnt_reg + IDX_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next        = 1'b1;
            m_item_next.nibble  = emit_nib;
            m_item_next.is_data = emit_data;
            m_item_next.last    = emit_last;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_item_next  = m_item_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            kind_reg        <= KIND_WINDOW;
            tracked_row_reg <= ROW_ONE;
            tracked_col_reg <= COL_ONE;
            fill_cnt_reg    <= '0;
            rot_cnt_reg     <= '0;
            addr_reg        <= CMD_ROW1_BASE;
            char_reg        <= CHAR_SPACE;
            m_valid_reg     <= 1'b0;
            m_item_reg      <= '0;
        end else begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            tracked_row_reg <= tracked_row_next;
            tracked_col_reg <= tracked_col_next;
            fill_cnt_reg    <= fill_cnt_next;
            rot_cnt_reg     <= rot_cnt_next;
            addr_reg        <= addr_next;
            char_reg        <= char_next;
            m_valid_reg     <= m_valid_next;
            m_item_reg      <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_cnt_reg <= FILL_MAX)
        else $error("scroll buffer fill count beyond line width");

    a_rot_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> rot_cnt_reg == '0)
        else $error("buffer rotation left unfinished");

    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.opcode == OP_SCROLL_PRINT |=>
        tracked_row_reg == ROW_TWO && tracked_col_reg == COL_ONE
        && state_reg == ST_CUR_HI)
        else $error("scroll print did not move cursor to second row");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && emit_last |=> state_reg == ST_IDLE || state_reg == ST_ROT)
        else $error("sequencer kept emitting after the final nibble");

    a_win_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.opcode == OP_WIN_PRINT |=>
        state_reg == ST_CLR_HI || state_reg == ST_CUR_HI || state_reg == ST_CHR_HI)
        else $error("window print took an unexpected path");

endmodule

// File: sim/char_lcd_text_window_scroller_tb.sv
// ============================================================================
// Character LCD text window scroller: testbench
// Drives print, cursor and clear requests through the input channel and
// checks every nibble write on the result channel against the directed
// table or a cycle-free model of the display front end kept inside this
// bench. A short table of directed items comes first, then bursts of random
// items, under three patterns of sender and receiver idling.
// ============================================================================
module char_lcd_text_window_scroller_tb;
    import lcdws_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 85;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int TIMEOUT_CYCLES = 400000;

    // Opcodes the block must ignore; the package names only the valid ones.
    localparam logic [2:0] OP_RESERVED_5 = 3'd5;
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    // One row of the directed table. When typed_exp is set, the writes the
    // row must produce are spelled out: n_wr nibbles, first one in the top
    // four bits of nibs, with the matching bit of data_mask marking data.
    // Otherwise the row is checked against the bench's own display model.
    typedef struct packed {
        lcdws_in_t   item;
        logic        typed_exp;
        logic [2:0]  n_wr;
        logic [23:0] nibs;
        logic [5:0]  data_mask;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // Window prints from reset: column 2, 3, 4, no cursor command.
        '{'{OP_WIN_PRINT,    8'h41, 2'd0,    5'd0},  1'b1, 3'd2, 24'h41_0000, 6'b110000},
        '{'{OP_WIN_PRINT,    8'hFF, 2'd0,    5'd0},  1'b1, 3'd2, 24'hFF_0000, 6'b110000},
        '{'{OP_WIN_PRINT,    8'h00, 2'd0,    5'd0},  1'b1, 3'd2, 24'h00_0000, 6'b110000},
        // End of row one, then a print that wraps onto row two.
        '{'{OP_SET_CURSOR,   8'h00, ROW_ONE, 5'd16}, 1'b1, 3'd2, 24'h8F_0000, 6'b000000},
        '{'{OP_WIN_PRINT,    8'h42, 2'd0,    5'd0},  1'b1, 3'd4, 24'hC0_4200, 6'b001100},
        // End of row two: the wrap clears the display and restarts row one.
        '{'{OP_SET_CURSOR,   8'h00, ROW_TWO, 5'd16}, 1'b1, 3'd2, 24'hCF_0000, 6'b000000},
        '{'{OP_WIN_PRINT,    8'h43, 2'd0,    5'd0},  1'b1, 3'd6, 24'h01_8043, 6'b000011},
        '{'{OP_CLR_DISPLAY,  8'h00, 2'd0,    5'd0},  1'b1, 3'd2, 24'h01_0000, 6'b000000},
        // Row zero and column zero: the address wraps below the row-two base.
        '{'{OP_SET_CURSOR,   8'h00, 2'd0,    5'd0},  1'b1, 3'd2, 24'hBF_0000, 6'b000000},
        '{'{OP_WIN_PRINT,    8'h5A, 2'd0,    5'd0},  1'b0, 3'd0, 24'h00_0000, 6'b000000},
        // Column 31: the column counter wraps to zero on the next print.
        '{'{OP_SET_CURSOR,   8'h00, ROW_OVF, 5'd31}, 1'b1, 3'd2, 24'hDE_0000, 6'b000000},
        '{'{OP_WIN_PRINT,    8'h61, 2'd0,    5'd0},  1'b0, 3'd0, 24'h00_0000, 6'b000000},
        // Row three steps to row zero without a clear.
        '{'{OP_SET_CURSOR,   8'h00, ROW_OVF, 5'd16}, 1'b1, 3'd2, 24'hCF_0000, 6'b000000},
        '{'{OP_WIN_PRINT,    8'h7E, 2'd0,    5'd0},  1'b0, 3'd0, 24'h00_0000, 6'b000000},
        // Column beyond the line width.
        '{'{OP_SET_CURSOR,   8'h00, ROW_ONE, 5'd17}, 1'b1, 3'd2, 24'h90_0000, 6'b000000},
        '{'{OP_WIN_PRINT,    8'h31, 2'd0,    5'd0},  1'b0, 3'd0, 24'h00_0000, 6'b000000},
        // Scroll prints: a full line of one character and spaces, then a send cut by a zero.
        '{'{OP_SCROLL_PRINT, 8'h48, 2'd0,    5'd0},  1'b0, 3'd0, 24'h00_0000, 6'b000000},
        '{'{OP_SCROLL_PRINT, 8'h00, 2'd0,    5'd0},  1'b0, 3'd0, 24'h00_0000, 6'b000000},
        '{'{OP_CLR_BUFFER,   8'h00, 2'd0,    5'd0},  1'b1, 3'd0, 24'h00_0000, 6'b000000},
        // Zero in the first entry: only the cursor command goes out.
        '{'{OP_SCROLL_PRINT, 8'h00, 2'd0,    5'd0},  1'b1, 3'd2, 24'hC0_0000, 6'b000000},
        // Unknown opcodes are dropped without a write.
        '{'{OP_RESERVED_5,   8'h00, 2'd0,    5'd0},  1'b1, 3'd0, 24'h00_0000, 6'b000000},
        '{'{OP_RESERVED_7,   8'hFF, ROW_OVF, 5'd31}, 1'b1, 3'd0, 24'h00_0000, 6'b000000},
        '{'{OP_RESERVED_6,   8'h5A, ROW_TWO, 5'd9},  1'b1, 3'd0, 24'h00_0000, 6'b000000},
        // Fields an opcode does not use must not leak into its writes.
        '{'{OP_SET_CURSOR,   8'hFF, ROW_TWO, 5'd1},  1'b1, 3'd2, 24'hC0_0000, 6'b000000},
        '{'{OP_CLR_DISPLAY,  8'hFF, ROW_OVF, 5'd31}, 1'b1, 3'd2, 24'h01_0000, 6'b000000}
    };

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    lcdws_in_t  s_item  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    lcdws_out_t m_item;

    // Idle percentages of the two sides, changed by the stimulus as it runs.
    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 67;

    // Display model state.
    logic [1:0] disp_row;
    logic [4:0] disp_col;
    logic [7:0] line_chars [LINE_WIDTH];
    int         line_fill;

    lcdws_out_t staged_writes [$];
    lcdws_out_t expected_writes [$];

    int mismatches        = 0;
    int items_sent        = 0;
    int writes_checked    = 0;
    int full_line_scrolls = 0;
    int row_wraps         = 0;

    char_lcd_text_window_scroller dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    // ------------------------------------------------------------------
    // Display model
    // ------------------------------------------------------------------
    function automatic void stage(input logic [3:0] nib, input logic data);
        lcdws_out_t wr;
        wr.nibble  = nib;
        wr.is_data = data;
        wr.last    = 1'b0;
        staged_writes.push_back(wr);
    endfunction

    function automatic void stage_char(input logic [7:0] c);
        stage(c[7:4], 1'b1);
        stage(c[3:0], 1'b1);
    endfunction

    function automatic void stage_clear();
        stage(CLR_NIB_HI, 1'b0);
        stage(CLR_NIB_LO, 1'b0);
        disp_row = ROW_ONE;
        disp_col = COL_ONE;
    endfunction

    // Any row other than one addresses the second line; the sum wraps in
    // eight bits, and the row and column are kept exactly as given.
    function automatic void stage_cursor(input logic [1:0] r, input logic [4:0] c);
        logic [7:0] addr;
        addr = ((r == ROW_ONE) ? CMD_ROW1_BASE : CMD_ROW2_BASE) + 8'(c) - 8'd1;
        stage(addr[7:4], 1'b0);
        stage(addr[3:0], 1'b0);
        disp_row = r;
        disp_col = c;
    endfunction

    function automatic void blank_line();
        for (int i = 0; i < LINE_WIDTH; i++) begin
            line_chars[i] = CHAR_SPACE;
        end
        line_fill = 0;
    endfunction

    // Works out the nibble writes of one item into staged_writes and
    // advances the model state.
    function automatic void predict_writes(input lcdws_in_t it);
        staged_writes.delete();
        case (it.opcode)
            OP_WIN_PRINT: begin
                disp_col = disp_col + 5'd1;
                if (disp_col > LINE_WIDTH) begin
                    disp_col = COL_ONE;
                    disp_row = disp_row + 2'd1;
                    row_wraps++;
                    // Only an exact step onto row three clears the display.
                    if (disp_row == ROW_OVF) begin
                        stage_clear();
                    end
                    stage_cursor(disp_row, disp_col);
                end
                stage_char(it.char_value);
            end
            OP_SCROLL_PRINT: begin
                stage_cursor(ROW_TWO, COL_ONE);
                if (line_fill >= LINE_WIDTH) begin
                    for (int i = 1; i < LINE_WIDTH; i++) begin
                        line_chars[i-1] = line_chars[i];
                    end
                    line_chars[LINE_WIDTH-1] = it.char_value;
                    full_line_scrolls++;
                end else begin
                    line_chars[line_fill] = it.char_value;
                    line_fill++;
                end
                for (int i = 0; i < LINE_WIDTH && line_chars[i] != CHAR_NUL; i++) begin
                    stage_char(line_chars[i]);
                end
            end
            OP_CLR_DISPLAY: begin
                stage_clear();
            end
            OP_SET_CURSOR: begin
                stage_cursor(it.cursor_row, it.cursor_col);
            end
            OP_CLR_BUFFER: begin
                blank_line();
            end
            default: begin
            end
        endcase
        if (staged_writes.size() > 0) begin
            staged_writes[staged_writes.size()-1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly printable characters, with zeros and arbitrary codes mixed in;
    // cursor fields are mostly on screen, sometimes anything the bits allow.
    function automatic lcdws_in_t random_item(input logic [2:0] op);
        lcdws_in_t   it;
        int unsigned roll;
        it.opcode = op;
        roll = $urandom_range(99);
        if (roll < 80) begin
            it.char_value = 8'($urandom_range(32, 126));
        end else if (roll < 88) begin
            it.char_value = CHAR_NUL;
        end else begin
            it.char_value = 8'($urandom_range(255));
        end
        if ($urandom_range(99) < 85) begin
            it.cursor_row = 2'($urandom_range(ROW_ONE, ROW_TWO));
            it.cursor_col = 5'($urandom_range(1, LINE_WIDTH));
        end else begin
            it.cursor_row = 2'($urandom_range(3));
            it.cursor_col = 5'($urandom_range(31));
        end
        return it;
    endfunction

    // Presents one item after an optional random gap, waits for it to be
    // taken and files the writes it must cause. Valid stays high after the
    // handshake so that back-to-back items need no extra assignment.
    task automatic present_item(input dir_row_t row);
        lcdws_out_t wr;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= row.item;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_writes(row.item);
        if (row.typed_exp) begin
            for (int k = 0; k < row.n_wr; k++) begin
                wr.nibble  = row.nibs[23-4*k -: 4];
                wr.is_data = row.data_mask[5-k];
                wr.last    = (k == row.n_wr - 1);
                expected_writes.push_back(wr);
            end
        end else begin
            foreach (staged_writes[k]) begin
                expected_writes.push_back(staged_writes[k]);
            end
        end
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Result side: check each write and drive ready with random stalls.
    // Signals are read right after the edge, so they hold the values the
    // block saw at that edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : write_check
        lcdws_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_writes.size() == 0) begin
                $error("write with nothing expected: nibble %h is_data %b last %b",
                       m_item.nibble, m_item.is_data, m_item.last);
                mismatches++;
            end else begin
                want = expected_writes.pop_front();
                writes_checked++;
                if (m_item.nibble !== want.nibble) begin
                    $error("nibble: expected %h, got %h", want.nibble, m_item.nibble);
                    mismatches++;
                end
                if (m_item.is_data !== want.is_data) begin
                    $error("is_data: expected %b, got %b", want.is_data, m_item.is_data);
                    mismatches++;
                end
                if (m_item.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_item.last);
                    mismatches++;
                end
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t    row;
        logic [2:0]  op;
        int unsigned kind;
        int unsigned burst_len;
        int          counted;
        int          drain;

        disp_row = ROW_ONE;
        disp_col = COL_ONE;
        blank_line();
        counted = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_TABLE[i]) begin
            present_item(DIR_TABLE[i]);
        end

        // Random part in bursts: runs of scroll prints fill and then shift
        // the line, runs of window prints walk across both rows and wrap,
        // and single commands move the cursor, clear things or carry an unknown opcode in between.
        while (counted < RANDOM_ITEMS) begin
            kind      = $urandom_range(99);
            burst_len = (kind < 75) ? $urandom_range(4, 24) : 1;
            if (burst_len > unsigned'(RANDOM_ITEMS - counted)) begin
                burst_len = unsigned'(RANDOM_ITEMS - counted);
            end
            repeat (burst_len) begin
                if (kind < 40) begin
                    op = OP_SCROLL_PRINT;
                end else if (kind < 75) begin
                    op = OP_WIN_PRINT;
                end else begin
                    case ($urandom_range(3))
                        0:       op = OP_SET_CURSOR;
                        1:       op = OP_CLR_DISPLAY;
                        2:       op = OP_CLR_BUFFER;
                        default: op = 3'($urandom_range(OP_RESERVED_5, OP_RESERVED_7));
                    endcase
                end
                // Receiver-heavy idling first, then sender-heavy, then none.
                send_idle_pct = (counted < 12) ? 38 : (counted < 49) ? 67 : 0;
                recv_idle_pct = (counted < 12) ? 67 : (counted < 49) ? 38 : 0;
                row = '{random_item(op), 1'b0, 3'd0, 24'd0, 6'd0};
                present_item(row);
                if (op < OP_RESERVED_5) begin
                    counted++;
                end
            end
        end
        s_valid <= 1'b0;

        drain = 0;
        while (expected_writes.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        // Let any stray write show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (expected_writes.size() != 0) begin
            $error("%0d expected nibble writes never arrived", expected_writes.size());
            mismatches++;
        end

        $display("Covered %0d items (%0d from the directed table) and %0d nibble writes,",
                 items_sent, DIR_ROWS, writes_checked);
        $display("with %0d row wraps and %0d scroll prints on a full line.",
                 row_wraps, full_line_scrolls);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/lcdws_pkg.sv
rtl/core/lcdws_cell.sv
rtl/core/lcdws_ctrl.sv
rtl/core/char_lcd_text_window_scroller.sv
sim/char_lcd_text_window_scroller_tb.sv
